// ===== design/bmpw_pkg.sv =====
// Package for the 24-bit BMP stream writer: sizes, register indexes,
// the command passed from front to back, back-end states and header helpers.
// No dependencies.
package bmpw_pkg;

  localparam int DIM_W     = 13;  // width/height register bits
  localparam int CNT_W     = 12;  // column and row counters
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 13;
  localparam int HIDX_W    = 6;   // header byte index
  localparam int PROD_W    = 28;  // row bytes times height

  localparam logic [DIM_W-1:0] MAX_WIDTH  = 13'd4096;
  localparam logic [DIM_W-1:0] MAX_HEIGHT = 13'd4096;

  localparam int HDR_BYTES      = 54;
  localparam int INFO_BYTES     = 40;
  localparam int BITS_PER_PIXEL = 3 * 8;
  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_M = 8'h4d;
  localparam logic [7:0] PLANES = 8'd1;

  localparam logic [HIDX_W-1:0] HDR_LAST = HIDX_W'(HDR_BYTES - 1);
  localparam logic [1:0]        PIX_LAST = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 8'd0,
    REG_IMAGE_HEIGHT   = 8'd1,
    REG_GREEN_FROM_RED = 8'd2,
    REG_BLUE_FROM_RED  = 8'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HDR,
    BK_PIX,
    BK_PAD
  } back_state_t;

  // One pixel, already classified by the front end
  typedef struct packed {
    logic       hdr;      // first pixel of an image
    logic [1:0] npad;     // padding bytes after this pixel
    logic       img_end;  // last pixel of the image
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

  // Byte idx of the 54-byte file header; everything not listed is zero
  function automatic logic [7:0] hdr_byte(input logic [HIDX_W-1:0] idx,
                                          input logic [DIM_W-1:0]  w,
                                          input logic [DIM_W-1:0]  h,
                                          input logic [31:0]       size);
    logic [7:0] b;
    case (idx)
      6'd0:    b = CHAR_B;
      6'd1:    b = CHAR_M;
      6'd2:    b = size[7:0];
      6'd3:    b = size[15:8];
      6'd4:    b = size[23:16];
      6'd5:    b = size[31:24];
      6'd10:   b = 8'(HDR_BYTES);
      6'd14:   b = 8'(INFO_BYTES);
      6'd18:   b = w[7:0];
      6'd19:   b = {3'b000, w[12:8]};
      6'd22:   b = h[7:0];
      6'd23:   b = {3'b000, h[12:8]};
      6'd26:   b = PLANES;
      6'd28:   b = 8'(BITS_PER_PIXEL);
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== design/bmpw_ifs.sv =====
// Valid/ready channel interfaces: RGB pixels in, BMP file bytes out.
// No dependencies.
interface bmpw_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface bmpw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_run;
  logic       last_of_image;

  modport source (output valid, data_byte, last_of_run, last_of_image, input ready);
  modport sink   (input valid, data_byte, last_of_run, last_of_image, output ready);
endinterface

// ===== design/bmp24_stream_writer_top.sv =====
// Channel    Dir  Payload                                  Transfer
// pixel      in   red, green, blue (8b each)               valid & ready
// stream     out  data_byte, last_of_run, last_of_image    valid & ready
// cfg        in   cfg_index, cfg_data (13b)                cfg_write
//
// The back end sends one byte per cycle while the output register can
// load: 3 bytes for a pixel, plus 54 header bytes on the first pixel of an
// image and 0 to 3 bytes of row padding. A command that reaches an idle back
// end is first loaded from the queue, then its first byte is registered.
// The front end classifies a pixel in the cycle it is taken and queues it in
// a two-entry command queue, so until the queue is full it keeps taking
// pixels while the back end works or the output register waits. Reset (rst,
// synchronous) clears counters, queue and output valid, sets width/height to 1.
// Top level of the BMP writer. Uses bmpw_pkg, bmpw_ifs, bmpw_front,
// bmpw_cmdq and bmpw_back.
module bmp24_stream_writer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bmpw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmpw_pkg::CFG_W-1:0]     cfg_data,
  bmpw_pix_if.sink                      pixel,
  bmpw_byte_if.source                   stream
);
  import bmpw_pkg::*;

  logic [DIM_W-1:0] image_width, image_height;
  logic             green_from_red, blue_from_red;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic             q_full, q_valid, q_push, q_pop;
  cmd_t             push_cmd, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= DIM_W'(1);
      image_height   <= DIM_W'(1);
      green_from_red <= 1'b0;
      blue_from_red  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    image_width    <= cfg_data;
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data;
        REG_GREEN_FROM_RED: green_from_red <= cfg_data[0];
        REG_BLUE_FROM_RED:  blue_from_red  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign w_eff = clamp_dim(image_width, MAX_WIDTH);
  assign h_eff = clamp_dim(image_height, MAX_HEIGHT);

  bmpw_front u_front (
    .clk            (clk),
    .rst            (rst),
    .pixel          (pixel),
    .width          (w_eff),
    .height         (h_eff),
    .green_from_red (green_from_red),
    .blue_from_red  (blue_from_red),
    .q_full         (q_full),
    .push           (q_push),
    .push_cmd       (push_cmd)
  );

  bmpw_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .head     (head)
  );

  bmpw_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (q_pop),
    .width   (w_eff),
    .height  (h_eff),
    .stream  (stream)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command popped from empty queue");

  a_image_end_ends_run: assert property (@(posedge clk) disable iff (rst)
    stream.valid && stream.last_of_image |-> stream.last_of_run)
    else $error("image end without run end");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !stream.valid)
    else $error("output valid right after reset");

  a_header_pushed_first: assert property (@(posedge clk) disable iff (rst)
    q_push && push_cmd.hdr && $past(q_push) && !$past(rst) |-> $past(push_cmd.img_end))
    else $error("new image started before previous one ended");

endmodule

// ===== design/bmpw_front.sv =====
// Front end: takes pixel requests, applies the color modes, tracks column
// and row, and classifies each pixel into a command. Uses bmpw_pkg, bmpw_ifs.
module bmpw_front (
  input  logic                      clk,
  input  logic                      rst,
  bmpw_pix_if.sink                  pixel,
  input  logic [bmpw_pkg::DIM_W-1:0] width,
  input  logic [bmpw_pkg::DIM_W-1:0] height,
  input  logic                      green_from_red,
  input  logic                      blue_from_red,
  input  logic                      q_full,
  output logic                      push,
  output bmpw_pkg::cmd_t            push_cmd
);
  import bmpw_pkg::*;

  logic [CNT_W-1:0] column_count, column_count_next;
  logic [CNT_W-1:0] row_count, row_count_next;
  logic             row_end, img_end;

  assign pixel.ready = !q_full;
  assign push        = pixel.valid && !q_full;

  assign row_end = ({1'b0, column_count} + DIM_W'(1)) >= width;
  assign img_end = row_end && (({1'b0, row_count} + DIM_W'(1)) >= height);

  always_comb begin
    push_cmd.hdr     = (column_count == '0) && (row_count == '0);
    // padding is (4 - 3w mod 4) mod 4, which equals w mod 4
    push_cmd.npad    = row_end ? width[1:0] : 2'd0;
    push_cmd.img_end = img_end;
    push_cmd.red     = pixel.red;
    push_cmd.green   = green_from_red ? pixel.red : pixel.green;
    push_cmd.blue    = blue_from_red ? pixel.red : pixel.blue;
  end

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (push) begin
      if (row_end) begin
        column_count_next = '0;
        row_count_next    = img_end ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count_next = column_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// ===== design/bmpw_cmdq.sv =====
// Two-entry command queue between front and back end.
// Uses bmpw_pkg.
module bmpw_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bmpw_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           q_valid,
  output bmpw_pkg::cmd_t head
);
  import bmpw_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/bmpw_back.sv =====
// Back end: turns commands into file bytes (header, B/G/R, padding), one
// byte per cycle while the output register can load. Uses bmpw_pkg, bmpw_ifs.
module bmpw_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  bmpw_pkg::cmd_t            head,
  output logic                      pop,
  input  logic [bmpw_pkg::DIM_W-1:0] width,
  input  logic [bmpw_pkg::DIM_W-1:0] height,
  bmpw_byte_if.source               stream
);
  import bmpw_pkg::*;

  back_state_t       state, state_next;
  logic [HIDX_W-1:0] idx, idx_next;
  cmd_t              cur, cur_next;
  logic [PROD_W-1:0] prod;
  logic [31:0]       size;
  logic [14:0]       row_bytes;
  logic              can_load, emit, finish;
  logic [7:0]        byte_val;
  logic              lr, li;

  // file size, two register stages behind the config registers
  assign row_bytes = 15'(3 * width) + 15'(width[1:0]);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(row_bytes) * PROD_W'(height);
    size <= 32'(HDR_BYTES) + 32'(prod);
  end

  assign can_load = !stream.valid || stream.ready;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cur_next   = cur;
    pop        = 1'b0;
    emit       = 1'b0;
    finish     = 1'b0;
    byte_val   = 8'h00;
    lr         = 1'b0;
    li         = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          cur_next   = head;
          idx_next   = '0;
          state_next = head.hdr ? BK_HDR : BK_PIX;
        end
      end
      BK_HDR: begin
        if (can_load) begin
          emit     = 1'b1;
          byte_val = hdr_byte(idx, width, height, size);
          if (idx == HDR_LAST) begin
            idx_next   = '0;
            state_next = BK_PIX;
          end else begin
            idx_next = idx + HIDX_W'(1);
          end
        end
      end
      BK_PIX: begin
        if (can_load) begin
          emit = 1'b1;
          case (idx[1:0])
            2'd0:    byte_val = cur.blue;
            2'd1:    byte_val = cur.green;
            default: byte_val = cur.red;
          endcase
          if (idx[1:0] == PIX_LAST) begin
            if (cur.npad == 2'd0) begin
              lr     = 1'b1;
              li     = cur.img_end;
              finish = 1'b1;
            end else begin
              idx_next   = '0;
              state_next = BK_PAD;
            end
          end else begin
            idx_next = idx + HIDX_W'(1);
          end
        end
      end
      BK_PAD: begin
        if (can_load) begin
          emit = 1'b1;
          if (idx[1:0] == cur.npad - 2'd1) begin
            lr     = 1'b1;
            li     = cur.img_end;
            finish = 1'b1;
          end else begin
            idx_next = idx + HIDX_W'(1);
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
    // chain straight into the next command to keep one byte per cycle while the output can load
    if (finish) begin
      idx_next = '0;
      if (q_valid) begin
        pop        = 1'b1;
        cur_next   = head;
        state_next = head.hdr ? BK_HDR : BK_PIX;
      end else begin
        state_next = BK_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream.valid <= 1'b0;
    end else if (emit) begin
      stream.valid <= 1'b1;
    end else if (stream.ready) begin
      stream.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      stream.data_byte     <= byte_val;
      stream.last_of_run   <= lr;
      stream.last_of_image <= li;
    end
  end

endmodule
